// ----- design/rm2q_pkg.sv -----
`timescale 1ns / 1ps
package rm2q_pkg;

   localparam int FRAC_BITS_DEFAULT = 14;
   localparam int ELEM_W            = 16;
   localparam int NUM_W             = 18;   // sum or difference of two elements
   localparam int MAG_W             = 17;
   localparam int QUOT_BITS         = 15;   // quotient bits below the saturation limit

   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_X     = 2'd1,
      BR_Y     = 2'd2,
      BR_Z     = 2'd3
   } branch_type;

   // n0..n2 are the off-diagonal numerators in x, y, z, w order, skipping
   // the component that comes from the root
   typedef struct packed {
      branch_type              branch;
      logic                    degen;
      logic signed [NUM_W-1:0] n0;
      logic signed [NUM_W-1:0] n1;
      logic signed [NUM_W-1:0] n2;
   } side_type;

   // unsigned radicand width: one + three full-scale elements
   function automatic int rad_w(input int f);
      return ((f > 17) ? f : 17) + 1;
   endfunction

   function automatic int sq_w(input int f);
      int s;
      s = rad_w(f) + f;
      return ((s + 1) / 2) * 2;
   endfunction

   function automatic int root_w(input int f);
      return sq_w(f) / 2;
   endfunction

   function automatic int cmp_w(input int f);
      int a;
      int b;
      a = MAG_W + f + 1;
      b = root_w(f) + 1 + QUOT_BITS;
      return (a > b) ? a : b;
   endfunction

endpackage

// ----- design/rm2q_front.sv -----
`timescale 1ns / 1ps
module rm2q_front #(
   parameter int FRAC_BITS = rm2q_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  logic                                     in_valid,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]       a11,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]       a12,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]       a13,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]       a21,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]       a22,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]       a23,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]       a31,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]       a32,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]       a33,
   output logic                                     out_valid,
   output rm2q_pkg::side_type                       out_side,
   output logic [rm2q_pkg::rad_w(FRAC_BITS)-1:0]    out_rad
);
   import rm2q_pkg::*;

   localparam int RADW = rad_w(FRAC_BITS);
   localparam int RSW  = RADW + 1;

   logic signed [17:0]      trace;
   logic signed [RSW-1:0]   e11, e22, e33, one_s, rad_s;
   logic signed [NUM_W-1:0] d_23_32, d_31_13, d_12_21, s_12_21, s_13_31, s_23_32;
   side_type                side_in, side_ff;
   logic [RADW-1:0]         rad_in, rad_ff;
   logic                    valid_ff;

   always_comb begin
      trace   = 18'(a11) + 18'(a22) + 18'(a33);
      e11     = RSW'(a11);
      e22     = RSW'(a22);
      e33     = RSW'(a33);
      one_s   = RSW'(1) <<< FRAC_BITS;
      d_23_32 = NUM_W'(a23) - NUM_W'(a32);
      d_31_13 = NUM_W'(a31) - NUM_W'(a13);
      d_12_21 = NUM_W'(a12) - NUM_W'(a21);
      s_12_21 = NUM_W'(a12) + NUM_W'(a21);
      s_13_31 = NUM_W'(a13) + NUM_W'(a31);
      s_23_32 = NUM_W'(a23) + NUM_W'(a32);

      if (trace > 18'sd0) begin
         side_in.branch = BR_TRACE;
         rad_s          = RSW'(trace) + one_s;
         side_in.n0     = d_23_32;
         side_in.n1     = d_31_13;
         side_in.n2     = d_12_21;
      end else if (a11 >= a22 && a11 >= a33) begin
         side_in.branch = BR_X;
         rad_s          = one_s + e11 - e22 - e33;
         side_in.n0     = s_12_21;
         side_in.n1     = s_13_31;
         side_in.n2     = d_23_32;
      end else if (a22 > a33) begin
         side_in.branch = BR_Y;
         rad_s          = one_s + e22 - e11 - e33;
         side_in.n0     = s_12_21;
         side_in.n1     = s_23_32;
         side_in.n2     = d_31_13;
      end else begin
         side_in.branch = BR_Z;
         rad_s          = one_s + e33 - e11 - e22;
         side_in.n0     = s_13_31;
         side_in.n1     = s_23_32;
         side_in.n2     = d_12_21;
      end
      side_in.degen = rad_s[RSW-1] || (rad_s == '0);
      rad_in        = side_in.degen ? '0 : rad_s[RADW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff <= side_in;
         rad_ff  <= rad_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_rad   = rad_ff;

endmodule

// ----- design/rm2q_sqrt.sv -----
`timescale 1ns / 1ps
module rm2q_sqrt #(
   parameter int FRAC_BITS = rm2q_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  logic                                     in_valid,
   input  rm2q_pkg::side_type                       in_side,
   input  logic [rm2q_pkg::rad_w(FRAC_BITS)-1:0]    in_rad,
   output logic                                     out_valid,
   output rm2q_pkg::side_type                       out_side,
   output logic [rm2q_pkg::root_w(FRAC_BITS)-1:0]   out_root
);
   import rm2q_pkg::*;

   localparam int SQW = sq_w(FRAC_BITS);
   localparam int RTW = root_w(FRAC_BITS);

   // one result bit per stage, digit pair taken from the top down
   logic [SQW-1:0] rem_ff [RTW];
   logic [SQW-1:0] res_ff [RTW];
   side_type       side_ff [RTW];
   logic           valid_ff [RTW];

   for (genvar k = 0; k < RTW; k++) begin : g_stage
      localparam logic [SQW-1:0] BitK = SQW'(1) << (SQW - 2 - 2 * k);
      logic [SQW-1:0] rem_i, res_i, trial, rem_in, res_in;
      side_type       side_i;
      logic           valid_i;

      if (k == 0) begin : g_first
         assign rem_i   = SQW'(in_rad) << FRAC_BITS;
         assign res_i   = '0;
         assign side_i  = in_side;
         assign valid_i = in_valid;
      end else begin : g_next
         assign rem_i   = rem_ff[k-1];
         assign res_i   = res_ff[k-1];
         assign side_i  = side_ff[k-1];
         assign valid_i = valid_ff[k-1];
      end

      always_comb begin
         trial = res_i + BitK;
         if (rem_i >= trial) begin
            rem_in = rem_i - trial;
            res_in = (res_i >> 1) + BitK;
         end else begin
            rem_in = rem_i;
            res_in = res_i >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_i;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            res_ff[k]  <= res_in;
            side_ff[k] <= side_i;
         end
      end
   end

   assign out_valid = valid_ff[RTW-1];
   assign out_side  = side_ff[RTW-1];
   assign out_root  = res_ff[RTW-1][RTW-1:0];

endmodule

// ----- design/rm2q_div.sv -----
`timescale 1ns / 1ps
module rm2q_div #(
   parameter int FRAC_BITS = rm2q_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  logic                                     in_valid,
   input  rm2q_pkg::side_type                       in_side,
   input  logic [rm2q_pkg::root_w(FRAC_BITS)-1:0]   in_root,
   output logic                                     out_valid,
   output rm2q_pkg::side_type                       out_side,
   output logic [rm2q_pkg::root_w(FRAC_BITS)-1:0]   out_root,
   output logic [rm2q_pkg::QUOT_BITS-1:0]           out_quot [3],
   output logic                                     out_ovf [3]
);
   import rm2q_pkg::*;

   localparam int RTW = root_w(FRAC_BITS);
   localparam int CW  = cmp_w(FRAC_BITS);
   localparam int NST = QUOT_BITS + 1;

   // stage 0 forms the rounded dividend and the saturation test,
   // stages 1..QUOT_BITS each resolve one quotient bit
   logic [CW-1:0]          rem_ff [NST][3];
   logic [QUOT_BITS-1:0]   quot_ff [NST][3];
   logic                   ovf_ff [NST][3];
   logic [CW-1:0]          dsor_ff [NST];
   side_type               side_ff [NST];
   logic                   valid_ff [NST];

   logic signed [NUM_W-1:0] num [3];
   logic [MAG_W-1:0]        mag [3];
   logic [CW-1:0]           dvd [3];
   logic [CW-1:0]           dsor_in;

   assign num[0] = in_side.n0;
   assign num[1] = in_side.n1;
   assign num[2] = in_side.n2;
   assign dsor_in = CW'(in_root) << 1;

   for (genvar l = 0; l < 3; l++) begin : g_prep
      assign mag[l] = num[l][NUM_W-1] ? MAG_W'(-num[l]) : MAG_W'(num[l]);
      assign dvd[l] = (CW'(mag[l]) << FRAC_BITS) + CW'(in_root);
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[0][l]  <= dvd[l];
            quot_ff[0][l] <= '0;
            ovf_ff[0][l]  <= dvd[l] >= (dsor_in << QUOT_BITS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dsor_ff[0] <= dsor_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar j = 1; j < NST; j++) begin : g_bit
      localparam int Sh = QUOT_BITS - j;
      logic [CW-1:0] step_d;
      assign step_d = dsor_ff[j-1] << Sh;

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic          take;
         logic [CW-1:0] rem_in;
         assign take   = rem_ff[j-1][l] >= step_d;
         assign rem_in = take ? rem_ff[j-1][l] - step_d : rem_ff[j-1][l];
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[j][l]  <= rem_in;
               quot_ff[j][l] <= {quot_ff[j-1][l][QUOT_BITS-2:0], take};
               ovf_ff[j][l]  <= ovf_ff[j-1][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (adv) begin
            valid_ff[j] <= valid_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dsor_ff[j] <= dsor_ff[j-1];
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   assign out_valid = valid_ff[NST-1];
   assign out_side  = side_ff[NST-1];
   assign out_root  = dsor_ff[NST-1][RTW:1];
   for (genvar l = 0; l < 3; l++) begin : g_out
      assign out_quot[l] = quot_ff[NST-1][l];
      assign out_ovf[l]  = ovf_ff[NST-1][l];
   end

endmodule

// ----- design/rotation_matrix_to_quaternion.sv -----
`timescale 1ns / 1ps
// Throughput: one matrix per cycle unless rsp stalls; the square root (one result bit per stage)
// and the three dividers (one quotient bit per stage) are fully pipelined.
// A stalled rsp holds the whole pipeline; req_ready drops only then.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
module rotation_matrix_to_quaternion #(
   parameter int FRAC_BITS = rm2q_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]   req_r1c1,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]   req_r1c2,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]   req_r1c3,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]   req_r2c1,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]   req_r2c2,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]   req_r2c3,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]   req_r3c1,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]   req_r3c2,
   input  logic signed [rm2q_pkg::ELEM_W-1:0]   req_r3c3,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [rm2q_pkg::ELEM_W-1:0]   rsp_quat_x,
   output logic signed [rm2q_pkg::ELEM_W-1:0]   rsp_quat_y,
   output logic signed [rm2q_pkg::ELEM_W-1:0]   rsp_quat_z,
   output logic signed [rm2q_pkg::ELEM_W-1:0]   rsp_quat_w,
   output logic [1:0]                           rsp_branch_taken,
   output logic                                 rsp_degenerate
);
   import rm2q_pkg::*;

   localparam int RADW = rad_w(FRAC_BITS);
   localparam int RTW  = root_w(FRAC_BITS);
   localparam int HRW  = (RTW > ELEM_W) ? RTW : ELEM_W;

   logic                 adv;
   logic                 f_valid, s_valid, d_valid;
   side_type             f_side, s_side, d_side;
   logic [RADW-1:0]      f_rad;
   logic [RTW-1:0]       s_root, d_root;
   logic [QUOT_BITS-1:0] d_quot [3];
   logic                 d_ovf [3];

   logic signed [ELEM_W-1:0] lane [3];
   logic signed [ELEM_W-1:0] diag;
   logic [HRW-1:0]           half_root;
   logic signed [ELEM_W-1:0] x_in, y_in, z_in, w_in;
   logic signed [ELEM_W-1:0] x_ff, y_ff, z_ff, w_ff;
   logic [1:0]               br_ff;
   logic                     degen_ff;
   logic                     valid_ff;

   assign adv       = !valid_ff || rsp_ready;
   assign req_ready = adv;

   rm2q_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .a11       (req_r1c1),
      .a12       (req_r1c2),
      .a13       (req_r1c3),
      .a21       (req_r2c1),
      .a22       (req_r2c2),
      .a23       (req_r2c3),
      .a31       (req_r3c1),
      .a32       (req_r3c2),
      .a33       (req_r3c3),
      .out_valid (f_valid),
      .out_side  (f_side),
      .out_rad   (f_rad)
   );

   rm2q_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_side   (f_side),
      .in_rad    (f_rad),
      .out_valid (s_valid),
      .out_side  (s_side),
      .out_root  (s_root)
   );

   rm2q_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s_valid),
      .in_side   (s_side),
      .in_root   (s_root),
      .out_valid (d_valid),
      .out_side  (d_side),
      .out_root  (d_root),
      .out_quot  (d_quot),
      .out_ovf   (d_ovf)
   );

   always_comb begin
      lane[0] = d_side.n0[NUM_W-1] ?
                (d_ovf[0] ? 16'sh8000 : -signed'(ELEM_W'(d_quot[0]))) :
                (d_ovf[0] ? 16'sh7fff : signed'(ELEM_W'(d_quot[0])));
      lane[1] = d_side.n1[NUM_W-1] ?
                (d_ovf[1] ? 16'sh8000 : -signed'(ELEM_W'(d_quot[1]))) :
                (d_ovf[1] ? 16'sh7fff : signed'(ELEM_W'(d_quot[1])));
      lane[2] = d_side.n2[NUM_W-1] ?
                (d_ovf[2] ? 16'sh8000 : -signed'(ELEM_W'(d_quot[2]))) :
                (d_ovf[2] ? 16'sh7fff : signed'(ELEM_W'(d_quot[2])));
      half_root = HRW'(d_root >> 1);
      diag = (half_root > HRW'(32767)) ? 16'sh7fff : signed'(half_root[ELEM_W-1:0]);

      case (d_side.branch)
         BR_TRACE: begin
            x_in = lane[0]; y_in = lane[1]; z_in = lane[2]; w_in = diag;
         end
         BR_X: begin
            x_in = diag; y_in = lane[0]; z_in = lane[1]; w_in = lane[2];
         end
         BR_Y: begin
            x_in = lane[0]; y_in = diag; z_in = lane[1]; w_in = lane[2];
         end
         default: begin
            x_in = lane[0]; y_in = lane[1]; z_in = diag; w_in = lane[2];
         end
      endcase

      if (d_side.degen) begin
         x_in = '0; y_in = '0; z_in = '0; w_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         w_ff     <= w_in;
         br_ff    <= d_side.branch;
         degen_ff <= d_side.degen;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_quat_x       = x_ff;
   assign rsp_quat_y       = y_ff;
   assign rsp_quat_z       = z_ff;
   assign rsp_quat_w       = w_ff;
   assign rsp_branch_taken = br_ff;
   assign rsp_degenerate   = degen_ff;

`ifndef ASSERT_OFF
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_quat_x == '0 && rsp_quat_y == '0 && rsp_quat_z == '0 && rsp_quat_w == '0)
      else $error("degenerate beat with nonzero quaternion");

   a_trace_w_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_branch_taken == BR_TRACE |-> !rsp_quat_w[ELEM_W-1])
      else $error("negative w on trace branch");

   a_x_branch_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_branch_taken == BR_X |-> !rsp_quat_x[ELEM_W-1])
      else $error("negative x on first-diagonal branch");
`endif

endmodule

// ----- tb/rotation_matrix_to_quaternion_tb.sv -----
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_tb;
   import rm2q_pkg::*;

   localparam int FB = FRAC_BITS_DEFAULT;
   localparam int LATENCY = 34;
   localparam int N_RANDOM = 520;

   typedef logic signed [15:0] elem_type;

   typedef struct packed {
      elem_type   qx;
      elem_type   qy;
      elem_type   qz;
      elem_type   qw;
      branch_type br;
      logic       degen;
   } quat_type;

   // integer square root, bitwise
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res;
      longint unsigned bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits >>= 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v -= res + bits;
            res = (res >> 1) + bits;
         end else begin
            res >>= 1;
         end
         bits >>= 2;
      end
      return res;
   endfunction

   function automatic longint half_root_quot(input longint n, input longint unsigned root);
      longint unsigned mag;
      longint unsigned q;
      mag = (n < 0) ? -n : n;
      q = ((mag << FB) + root) / (2 * root);
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic elem_type clamp16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return elem_type'(v);
   endfunction

   function automatic quat_type matrix_to_quat(input elem_type m[9]);
      longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
      longint one, tr, rad, x, y, z, w, d;
      longint unsigned root;
      quat_type q;
      a11 = m[0]; a12 = m[1]; a13 = m[2];
      a21 = m[3]; a22 = m[4]; a23 = m[5];
      a31 = m[6]; a32 = m[7]; a33 = m[8];
      one = 64'sd1 << FB;
      tr = a11 + a22 + a33;
      if (tr > 0) begin
         q.br = BR_TRACE; rad = tr + one;
      end else if (a11 >= a22 && a11 >= a33) begin
         q.br = BR_X; rad = one + a11 - a22 - a33;
      end else if (a22 > a33) begin
         q.br = BR_Y; rad = one + a22 - a11 - a33;
      end else begin
         q.br = BR_Z; rad = one + a33 - a11 - a22;
      end
      q.qx = 0; q.qy = 0; q.qz = 0; q.qw = 0; q.degen = 1'b1;
      if (rad <= 0) return q;
      root = int_sqrt(longint'(rad) << FB);
      d = root >> 1;
      case (q.br)
         BR_TRACE: begin
            w = d;
            x = half_root_quot(a23 - a32, root);
            y = half_root_quot(a31 - a13, root);
            z = half_root_quot(a12 - a21, root);
         end
         BR_X: begin
            x = d;
            y = half_root_quot(a12 + a21, root);
            z = half_root_quot(a13 + a31, root);
            w = half_root_quot(a23 - a32, root);
         end
         BR_Y: begin
            y = d;
            x = half_root_quot(a21 + a12, root);
            z = half_root_quot(a32 + a23, root);
            w = half_root_quot(a31 - a13, root);
         end
         default: begin
            z = d;
            x = half_root_quot(a13 + a31, root);
            y = half_root_quot(a23 + a32, root);
            w = half_root_quot(a12 - a21, root);
         end
      endcase
      q.qx = clamp16(x); q.qy = clamp16(y); q.qz = clamp16(z); q.qw = clamp16(w);
      q.degen = 1'b0;
      return q;
   endfunction

   class quat_scoreboard;
      quat_type pending[$];
      int errors = 0;
      int checked = 0;
      int n_degen = 0;
      int n_branch[4] = '{0, 0, 0, 0};

      function void note_matrix(input elem_type m[9]);
         pending.push_back(matrix_to_quat(m));
      endfunction

      function void check_quat(input quat_type got);
         quat_type exp_q;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected rsp beat: %p", got);
            return;
         end
         exp_q = pending.pop_front();
         checked++;
         n_branch[exp_q.br]++;
         if (exp_q.degen) n_degen++;
         if (got !== exp_q) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch #%0d: exp x=%0d y=%0d z=%0d w=%0d br=%0d dg=%0b,",
                         " got x=%0d y=%0d z=%0d w=%0d br=%0d dg=%0b"},
                        checked, exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw, exp_q.br,
                        exp_q.degen, got.qx, got.qy, got.qz, got.qw, got.br, got.degen);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   elem_type req_r1c1 = 0, req_r1c2 = 0, req_r1c3 = 0;
   elem_type req_r2c1 = 0, req_r2c2 = 0, req_r2c3 = 0;
   elem_type req_r3c1 = 0, req_r3c2 = 0, req_r3c3 = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   elem_type rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;
   logic [1:0] rsp_branch_taken;
   logic rsp_degenerate;

   quat_scoreboard sb = new();
   bit quiet_phase = 0;
   bit hold_rsp = 0;
   bit stim_done = 0;

   always #5 clock = ~clock;

   rotation_matrix_to_quaternion DUT (.*);

   task automatic send_matrix(input elem_type m[9]);
      int gap;
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_r1c1, req_r1c2, req_r1c3, req_r2c1, req_r2c2, req_r2c3, req_r3c1, req_r3c2,
       req_r3c3} <= {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
      do @(posedge clock); while (!req_ready);
      sb.note_matrix(m);
   endtask

   task automatic send_diag(input int a, input int b, input int c, input int o);
      elem_type m[9];
      m = '{elem_type'(a), elem_type'(o), elem_type'(-o), elem_type'(-o), elem_type'(b),
            elem_type'(o), elem_type'(o), elem_type'(-o), elem_type'(c)};
      send_matrix(m);
   endtask

   // rough random rotation-like matrix: diagonal signs favour one branch, off-diagonals within +-16000
   task automatic send_rotation_like();
      elem_type m[9];
      int k;
      for (int i = 0; i < 9; i++) m[i] = elem_type'($urandom_range(0, 32000) - 16000);
      k = $urandom_range(0, 3);
      case (k)
         0: begin
            m[0] = elem_type'($urandom_range(0, 16384));
            m[4] = elem_type'($urandom_range(0, 16384));
            m[8] = elem_type'($urandom_range(0, 16384));
         end
         1: begin
            m[0] = elem_type'($urandom_range(0, 16384));
            m[4] = elem_type'(-$urandom_range(0, 16384));
            m[8] = elem_type'(-$urandom_range(0, 16384));
         end
         2: begin
            m[4] = elem_type'($urandom_range(0, 16384));
            m[0] = elem_type'(-$urandom_range(0, 16384));
            m[8] = elem_type'(-$urandom_range(0, 16384));
         end
         default: begin
            m[8] = elem_type'($urandom_range(0, 16384));
            m[0] = elem_type'(-$urandom_range(0, 16384));
            m[4] = elem_type'(-$urandom_range(0, 16384));
         end
      endcase
      send_matrix(m);
   endtask

   task automatic send_noise();
      elem_type m[9];
      for (int i = 0; i < 9; i++) m[i] = elem_type'($urandom());
      send_matrix(m);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // identity, half-turns about each axis, ties among diagonals
      send_diag(16384, 16384, 16384, 0);
      send_diag(16384, -16384, -16384, 0);
      send_diag(-16384, 16384, -16384, 0);
      send_diag(-16384, -16384, 16384, 0);
      send_diag(0, 0, 0, 0);
      send_diag(-16384, -16384, -16384, 0);
      send_diag(-8192, -8192, -8192, 100);
      send_diag(-32768, -32768, -32768, -32768);
      send_diag(32767, 32767, 32767, 32767);
      send_diag(32767, -32768, -32768, 32767);
      send_diag(-32768, 32767, -32768, -32768);
      send_diag(-32768, -32768, 32767, 32767);
      send_diag(1, 0, 0, 32767);
      send_diag(0, 0, 1, -32768);
      send_diag(-5000, -5000, 0, 12000);
      send_diag(-20000, -20000, -20000, 20000);
      send_diag(0, -16384, 0, 16000);
      send_diag(-1, -1, 2, 5);
      // receiver holds off while the sender keeps going
      hold_rsp = 1;
      for (int i = 0; i < 60; i++) send_rotation_like();
      // sender pauses until drained
      req_valid <= 1'b0;
      wait (sb.pending.size() == 0);
      @(posedge clock);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i > N_RANDOM - 100) quiet_phase = 1;
         if ($urandom_range(0, 3) == 0) send_noise();
         else send_rotation_like();
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   // receiver: random stall bursts, long hold on request
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_rsp = 0;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_quat({rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w,
                        branch_type'(rsp_branch_taken), rsp_degenerate});
   end

   initial begin
      wait (stim_done);
      wait (sb.pending.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Checked %0d quaternions: branches %0d/%0d/%0d/%0d, %0d degenerate.",
               sb.checked, sb.n_branch[0], sb.n_branch[1], sb.n_branch[2], sb.n_branch[3],
               sb.n_degen);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("timeout");
      $display("Some tests failed");
      $finish;
   end
endmodule
